[hdl/mtep_pkg.sv]
// ----------------------------------------------------------------------------
// MIDI track event parser package
// Shared types, status codes and the byte classification helper.
// ----------------------------------------------------------------------------
package mtep_pkg;

  localparam int ValueWidth = 28;
  localparam int QueueDepth = 2;

  localparam logic [7:0] STATUS_NONE      = 8'h00;
  localparam logic [7:0] STATUS_SYSEX     = 8'hF0;
  localparam logic [7:0] STATUS_SYSEX_ESC = 8'hF7;
  localparam logic [7:0] STATUS_META      = 8'hFF;
  localparam logic [7:0] STATUS_ONE_LO    = 8'hC0;
  localparam logic [7:0] STATUS_ONE_HI    = 8'hDF;
  localparam logic [7:0] STATUS_SYS_LO    = 8'hF0;

  typedef enum logic [2:0] {
    BC_DATA,
    BC_CHANNEL,
    BC_SYSEX,
    BC_META,
    BC_UNDEF
  } byte_class_t;

  typedef enum logic [3:0] {
    PH_DELTA     = 4'd0,
    PH_STATUS    = 4'd1,
    PH_DATA      = 4'd2,
    PH_DATA_RUN  = 4'd3,
    PH_META_TYPE = 4'd4,
    PH_LEN       = 4'd5,
    PH_SKIP      = 4'd6
  } phase_t;

  typedef enum logic [1:0] {
    KIND_CHANNEL = 2'd0,
    KIND_SYSEX   = 2'd1,
    KIND_META    = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE         = 2'd0,
    ERR_NO_RUNNING   = 2'd1,
    ERR_UNDEF_STATUS = 2'd2,
    ERR_TOO_LONG     = 2'd3
  } err_t;

  // One classified byte as it travels through the queue.
  typedef struct packed {
    logic [7:0]  data;
    logic        new_track;
    byte_class_t cls;
    logic        one_data;
  } entry_t;

  typedef struct packed {
    kind_t                 kind;
    logic [ValueWidth-1:0] delta;
    logic [7:0]            status;
    logic [6:0]            first_data;
    logic [6:0]            second_data;
    logic [1:0]            count;
    logic                  used_running;
    logic [6:0]            meta_kind;
    logic [ValueWidth-1:0] plen;
    err_t                  err;
  } record_t;

  // Program change and channel pressure carry a single data byte.
  function automatic logic is_one_data(input logic [7:0] st);
    return (st >= STATUS_ONE_LO) && (st <= STATUS_ONE_HI);
  endfunction

endpackage

[hdl/midi_track_event_parser.sv]
// ----------------------------------------------------------------------------
// MIDI track event parser
// Decodes track chunk bytes into channel, sysex, meta and error records.
//
//   channel  direction  handshake             payload
//   input    in         in_valid / in_ready   data_byte, new_track
//   output   out        out_valid / out_ready event_kind .. error_code
//
// One byte is taken every cycle while the output side keeps up; the rate is
// set by the parser state update in the back end. An accepted byte is
// written into the queue and parsed when the back end pops it, and a record
// that it completes is registered in the result slot.
// The two-entry queue lets the input run on while a record waits.
// Reset clears the queue, the parser state and the result slot at once.
// ----------------------------------------------------------------------------
module midi_track_event_parser
  import mtep_pkg::*;
#(
  parameter int MAX_VLQ_BYTES = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        new_track,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  event_kind,
  output logic [27:0] delta_ticks,
  output logic [7:0]  status_byte,
  output logic [6:0]  first_data,
  output logic [6:0]  second_data,
  output logic [1:0]  data_count,
  output logic        used_running,
  output logic [6:0]  meta_kind,
  output logic [27:0] payload_length,
  output logic [1:0]  error_code
);

  entry_t  entry;
  entry_t  head;
  logic    q_valid;
  logic    q_pop;
  record_t rec;

  mtep_front u_front (
    .data_byte (data_byte),
    .new_track (new_track),
    .entry     (entry)
  );

  mtep_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (in_valid && in_ready),
    .push_entry (entry),
    .not_full   (in_ready),
    .pop        (q_pop),
    .not_empty  (q_valid),
    .head       (head)
  );

  mtep_back #(
    .MAX_VLQ_BYTES (MAX_VLQ_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_head    (head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rec   (rec)
  );

  assign event_kind     = rec.kind;
  assign delta_ticks    = rec.delta;
  assign status_byte    = rec.status;
  assign first_data     = rec.first_data;
  assign second_data    = rec.second_data;
  assign data_count     = rec.count;
  assign used_running   = rec.used_running;
  assign meta_kind      = rec.meta_kind;
  assign payload_length = rec.plen;
  assign error_code     = rec.err;

endmodule

[hdl/mtep_front.sv]
// ----------------------------------------------------------------------------
// MIDI track event parser front end
// Classifies each incoming byte by status range before it is queued.
// ----------------------------------------------------------------------------
module mtep_front
  import mtep_pkg::*;
(
  input  logic [7:0] data_byte,
  input  logic       new_track,
  output entry_t     entry
);

  byte_class_t cls;

  always_comb begin
    if (!data_byte[7]) begin
      cls = BC_DATA;
    end else if (data_byte < STATUS_SYS_LO) begin
      cls = BC_CHANNEL;
    end else if (data_byte == STATUS_SYSEX || data_byte == STATUS_SYSEX_ESC) begin
      cls = BC_SYSEX;
    end else if (data_byte == STATUS_META) begin
      cls = BC_META;
    end else begin
      cls = BC_UNDEF;
    end
  end

  assign entry.data      = data_byte;
  assign entry.new_track = new_track;
  assign entry.cls       = cls;
  assign entry.one_data  = is_one_data(data_byte);

endmodule

[hdl/mtep_queue.sv]
// ----------------------------------------------------------------------------
// MIDI track event parser queue
// Two-entry queue between the classifier and the parser.
// ----------------------------------------------------------------------------
module mtep_queue
  import mtep_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   not_full,
  input  logic   pop,
  output logic   not_empty,
  output entry_t head
);

  localparam int PtrWidth = $clog2(QueueDepth);
  localparam int CntWidth = $clog2(QueueDepth + 1);

  entry_t              mem [QueueDepth];
  logic [PtrWidth-1:0] wr_ptr;
  logic [PtrWidth-1:0] rd_ptr;
  logic [CntWidth-1:0] count;

  assign not_full  = (count != CntWidth'(QueueDepth));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[hdl/mtep_back.sv]
// ----------------------------------------------------------------------------
// MIDI track event parser back end
// Event state machine with running status, length decoding and payload
// skipping, feeding a registered result slot.
// ----------------------------------------------------------------------------
module mtep_back
  import mtep_pkg::*;
#(
  parameter int MAX_VLQ_BYTES = 4
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    q_valid,
  input  entry_t  q_head,
  output logic    q_pop,
  output logic    out_valid,
  input  logic    out_ready,
  output record_t out_rec
);

  localparam int CntWidth = $clog2(MAX_VLQ_BYTES + 1);

  phase_t                phase, phase_next;
  logic [ValueWidth-1:0] acc, acc_next;
  logic [CntWidth-1:0]   cnt, cnt_next;
  logic [ValueWidth-1:0] latched_delta, latched_delta_next;
  logic [7:0]            running, running_next;
  logic [7:0]            cur_status, cur_status_next;
  logic [6:0]            held_first, held_first_next;
  logic [1:0]            left, left_next;
  logic [ValueWidth-1:0] skip, skip_next;
  logic [6:0]            held_meta, held_meta_next;
  logic                  out_valid_next;
  record_t               out_rec_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_DELTA;
      acc           <= '0;
      cnt           <= '0;
      latched_delta <= '0;
      running       <= STATUS_NONE;
      cur_status    <= STATUS_NONE;
      held_first    <= '0;
      left          <= '0;
      skip          <= '0;
      held_meta     <= '0;
      out_valid     <= 1'b0;
    end else begin
      phase         <= phase_next;
      acc           <= acc_next;
      cnt           <= cnt_next;
      latched_delta <= latched_delta_next;
      running       <= running_next;
      cur_status    <= cur_status_next;
      held_first    <= held_first_next;
      left          <= left_next;
      skip          <= skip_next;
      held_meta     <= held_meta_next;
      out_valid     <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_rec <= out_rec_next;
  end

  always_comb begin
    phase_t                ph;
    logic [ValueWidth-1:0] acc_eff;
    logic [CntWidth-1:0]   cnt_eff;
    logic [ValueWidth-1:0] acc_take;
    logic [CntWidth-1:0]   cnt_take;
    logic                  vlq_done;
    logic                  vlq_long;
    logic [6:0]            d;
    logic                  emit;
    logic                  is_meta;
    record_t               r;

    // A result can be produced only when the output slot is free or draining.
    q_pop = q_valid && (!out_valid || out_ready);

    phase_next         = phase;
    acc_next           = acc;
    cnt_next           = cnt;
    latched_delta_next = latched_delta;
    running_next       = running;
    cur_status_next    = cur_status;
    held_first_next    = held_first;
    left_next          = left;
    skip_next          = skip;
    held_meta_next     = held_meta;
    out_valid_next     = out_valid && !out_ready;
    out_rec_next       = out_rec;

    ph      = phase;
    acc_eff = acc;
    cnt_eff = cnt;
    if (q_pop && q_head.new_track) begin
      ph           = PH_DELTA;
      acc_eff      = '0;
      cnt_eff      = '0;
      running_next = STATUS_NONE;
    end
    acc_take = {acc_eff[ValueWidth-8:0], q_head.data[6:0]};
    cnt_take = cnt_eff + 1'b1;
    vlq_done = !q_head.data[7];
    vlq_long = (cnt_take >= CntWidth'(MAX_VLQ_BYTES));
    d        = q_head.data[6:0];
    is_meta  = (cur_status == STATUS_META);
    emit     = 1'b0;

    r              = '0;
    r.kind         = KIND_ERROR;
    r.err          = ERR_NONE;
    r.delta        = latched_delta;

    if (q_pop) begin
      phase_next = ph;
      acc_next   = acc_eff;
      cnt_next   = cnt_eff;

      case (ph)
        PH_STATUS: begin
          case (q_head.cls)
            BC_DATA: begin
              if (running_next == STATUS_NONE) begin
                emit       = 1'b1;
                r.err      = ERR_NO_RUNNING;
                phase_next = PH_DELTA;
                acc_next   = '0;
                cnt_next   = '0;
              end else begin
                cur_status_next = running_next;
                if (is_one_data(running_next)) begin
                  emit           = 1'b1;
                  r.kind         = KIND_CHANNEL;
                  r.status       = running_next;
                  r.first_data   = d;
                  r.count        = 2'd1;
                  r.used_running = 1'b1;
                  phase_next     = PH_DELTA;
                  acc_next       = '0;
                  cnt_next       = '0;
                end else begin
                  held_first_next = d;
                  left_next       = 2'd1;
                  phase_next      = PH_DATA_RUN;
                end
              end
            end
            BC_CHANNEL: begin
              running_next    = q_head.data;
              cur_status_next = q_head.data;
              left_next       = q_head.one_data ? 2'd1 : 2'd2;
              held_first_next = '0;
              phase_next      = PH_DATA;
            end
            BC_SYSEX: begin
              running_next    = STATUS_NONE;
              cur_status_next = q_head.data;
              held_meta_next  = '0;
              acc_next        = '0;
              cnt_next        = '0;
              phase_next      = PH_LEN;
            end
            BC_META: begin
              running_next    = STATUS_NONE;
              cur_status_next = q_head.data;
              phase_next      = PH_META_TYPE;
            end
            default: begin
              emit       = 1'b1;
              r.status   = q_head.data;
              r.err      = ERR_UNDEF_STATUS;
              phase_next = PH_DELTA;
              acc_next   = '0;
              cnt_next   = '0;
            end
          endcase
        end

        PH_DATA, PH_DATA_RUN: begin
          if (left >= 2'd2) begin
            held_first_next = d;
            left_next       = 2'd1;
          end else begin
            emit           = 1'b1;
            r.kind         = KIND_CHANNEL;
            r.status       = cur_status;
            r.used_running = (ph == PH_DATA_RUN);
            if (is_one_data(cur_status)) begin
              r.first_data = d;
              r.count      = 2'd1;
            end else begin
              r.first_data  = held_first;
              r.second_data = d;
              r.count       = 2'd2;
            end
            left_next  = '0;
            phase_next = PH_DELTA;
            acc_next   = '0;
            cnt_next   = '0;
          end
        end

        PH_META_TYPE: begin
          held_meta_next = d;
          acc_next       = '0;
          cnt_next       = '0;
          phase_next     = PH_LEN;
        end

        PH_LEN: begin
          acc_next = acc_take;
          cnt_next = cnt_take;
          if (vlq_done) begin
            skip_next = acc_take;
            if (acc_take == '0) begin
              emit        = 1'b1;
              r.kind      = is_meta ? KIND_META : KIND_SYSEX;
              r.status    = cur_status;
              r.meta_kind = is_meta ? held_meta : '0;
              r.plen      = acc_take;
              phase_next  = PH_DELTA;
              acc_next    = '0;
              cnt_next    = '0;
            end else begin
              phase_next = PH_SKIP;
            end
          end else if (vlq_long) begin
            emit       = 1'b1;
            r.err      = ERR_TOO_LONG;
            phase_next = PH_DELTA;
            acc_next   = '0;
            cnt_next   = '0;
          end
        end

        PH_SKIP: begin
          skip_next = skip - 1'b1;
          if (skip == ValueWidth'(1)) begin
            emit        = 1'b1;
            r.kind      = is_meta ? KIND_META : KIND_SYSEX;
            r.status    = cur_status;
            r.meta_kind = is_meta ? held_meta : '0;
            r.plen      = acc_eff;
            phase_next  = PH_DELTA;
            acc_next    = '0;
            cnt_next    = '0;
          end
        end

        // Delta time, and any unused phase code.
        default: begin
          acc_next = acc_take;
          cnt_next = cnt_take;
          if (vlq_done) begin
            latched_delta_next = acc_take;
            acc_next           = '0;
            cnt_next           = '0;
            phase_next         = PH_STATUS;
          end else if (vlq_long) begin
            emit       = 1'b1;
            r.delta    = acc_take;
            r.err      = ERR_TOO_LONG;
            phase_next = PH_DELTA;
            acc_next   = '0;
            cnt_next   = '0;
          end else begin
            phase_next = PH_DELTA;
          end
        end
      endcase

      if (emit) begin
        out_valid_next = 1'b1;
        out_rec_next   = r;
      end
    end
  end

endmodule

[hdl/mtep_checker.sv]
// ----------------------------------------------------------------------------
// MIDI track event parser checker
// Port-level checks on the result records, bound to the top level.
// ----------------------------------------------------------------------------
module mtep_checker
  import mtep_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  event_kind,
  input logic [27:0] delta_ticks,
  input logic [7:0]  status_byte,
  input logic [1:0]  data_count,
  input logic [6:0]  meta_kind,
  input logic [27:0] payload_length,
  input logic [1:0]  error_code
);

  // A record waiting on the output holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(event_kind)
      && $stable(delta_ticks) && $stable(status_byte) && $stable(payload_length))
    else $error("output record changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result slot not cleared by reset");

  a_error_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((event_kind == KIND_ERROR) == (error_code != ERR_NONE)))
    else $error("error code does not match event kind");

  a_channel_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind == KIND_CHANNEL |->
      status_byte[7] && (data_count == 2'd1 || data_count == 2'd2)
      && meta_kind == '0 && payload_length == '0)
    else $error("malformed channel record");

  a_payload_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_kind == KIND_SYSEX || event_kind == KIND_META) |->
      data_count == 2'd0 && status_byte[7:4] == 4'hF)
    else $error("malformed sysex or meta record");

endmodule

bind midi_track_event_parser mtep_checker u_mtep_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .event_kind     (event_kind),
  .delta_ticks    (delta_ticks),
  .status_byte    (status_byte),
  .data_count     (data_count),
  .meta_kind      (meta_kind),
  .payload_length (payload_length),
  .error_code     (error_code)
);
